>>> hdl/gfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Goldilocks field ALU package
// Shared constants, operation codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package gfa_pkg;

   localparam int FUNC_W = 3;
   localparam int DATA_W = 64;

   localparam logic [DATA_W-1:0] FIELD_P    = 64'hFFFF_FFFF_0000_0001;
   localparam logic [DATA_W-1:0] FOLD_K     = 64'h0000_0000_FFFF_FFFF;
   localparam logic [DATA_W-1:0] TWO_K      = 64'h0000_0001_FFFF_FFFE;
   localparam logic [DATA_W-1:0] HALF_P1    = 64'h7FFF_FFFF_8000_0001;
   localparam logic [DATA_W-1:0] INV_EXP    = 64'hFFFF_FFFE_FFFF_FFFF;
   localparam logic [DATA_W-1:0] FIELD_ONE  = 64'h0000_0000_0000_0001;
   localparam int                SQRT_SHIFT = 48;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD  = 3'd0,
      FUNC_SUB  = 3'd1,
      FUNC_MUL  = 3'd2,
      FUNC_SQRT = 3'd3,
      FUNC_HALF = 3'd4,
      FUNC_POW  = 3'd5,
      FUNC_INV  = 3'd6
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ARITH1,
      ST_ARITH2,
      ST_SQRT,
      ST_POW_CHECK,
      ST_MUL_LOAD,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_ACC,
      ST_FOLD1,
      ST_FOLD2,
      ST_FOLD3,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      KIND_AB,
      KIND_SQRT,
      KIND_RY,
      KIND_YY,
      KIND_FINAL
   } kind_type;

   typedef enum logic [1:0] {
      MS_AB,
      MS_RY,
      MS_YY
   } mul_src_type;

   typedef enum logic [1:0] {
      WB_NONE,
      WB_R,
      WB_Y,
      WB_RES
   } wb_sel_type;

   typedef struct packed {
      logic        capture;
      logic        canon;
      logic        arith1;
      logic        arith2;
      logic        mul_load;
      mul_src_type mul_src;
      logic        mul_step;
      logic [1:0]  step_idx;
      logic        acc_clear;
      logic        acc_add;
      logic        sqrt_load;
      logic        fold1;
      logic        fold2;
      wb_sel_type  wb_sel;
      logic        exp_shift;
      logic        set_one;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     exp_zero;
      logic     exp_one;
      logic     exp_odd;
   } status_type;

endpackage
`default_nettype wire

>>> hdl/gfa_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Carries one operation word: function code and two 64-bit operands.
// ----------------------------------------------------------------------------
interface gfa_req_if;
   import gfa_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [DATA_W-1:0] operand_a;
   logic [DATA_W-1:0] operand_b;

   modport source (output valid, func, operand_a, operand_b, input ready);
   modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

>>> hdl/gfa_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Carries one result word holding a field element.
// ----------------------------------------------------------------------------
interface gfa_rsp_if;
   import gfa_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface
`default_nettype wire

>>> hdl/gfa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Goldilocks field ALU datapath
// Operand registers, a shared 32x32 multiplier with a 128-bit accumulator,
// a three-step folding reduction and the add, subtract and halve logic.
// ----------------------------------------------------------------------------
module gfa_datapath (
   input  wire logic                      clock,
   input  wire gfa_pkg::cmd_type          cmd,
   input  wire logic [gfa_pkg::FUNC_W-1:0] req_func,
   input  wire logic [gfa_pkg::DATA_W-1:0] req_operand_a,
   input  wire logic [gfa_pkg::DATA_W-1:0] req_operand_b,
   output gfa_pkg::status_type            status,
   output logic [gfa_pkg::DATA_W-1:0]     rsp_result
);
   import gfa_pkg::*;

   func_type          func_ff,  func_in;
   logic [DATA_W-1:0] raw_a_ff, raw_a_in;
   logic [DATA_W-1:0] raw_b_ff, raw_b_in;
   logic [DATA_W-1:0] a_ff,     a_in;
   logic [DATA_W-1:0] b_ff,     b_in;
   logic [DATA_W-1:0] r_ff,     r_in;
   logic [DATA_W-1:0] y_ff,     y_in;
   logic [DATA_W-1:0] e_ff,     e_in;
   logic [DATA_W:0]   t_ff,     t_in;
   logic [DATA_W-1:0] mx_ff,    mx_in;
   logic [DATA_W-1:0] my_ff,    my_in;
   logic [DATA_W-1:0] pp_ff,    pp_in;
   logic [1:0]        pp_idx_ff, pp_idx_in;
   logic [2*DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] s_ff,     s_in;
   logic [DATA_W-1:0] lo_ff,    lo_in;
   logic [DATA_W-1:0] fsum_ff,  fsum_in;
   logic              fcarry_ff, fcarry_in;
   logic [DATA_W-1:0] res_ff,   res_in;

   logic [DATA_W-1:0]   canon_a;
   logic [DATA_W-1:0]   canon_b;
   logic [DATA_W-1:0]   arith_value;
   logic [DATA_W-1:0]   fold_value;
   logic [DATA_W/2-1:0] mul_x;
   logic [DATA_W/2-1:0] mul_y;
   logic [2*DATA_W-1:0] pp_shifted;
   logic [DATA_W/2-1:0] h_lo;
   logic [DATA_W/2-1:0] h_hi;

   function automatic logic [DATA_W-1:0] canon(input logic [DATA_W-1:0] x);
      canon = (x >= FIELD_P) ? x - FIELD_P : x;
   endfunction

   always_comb begin
      canon_a = canon(raw_a_ff);
      canon_b = canon(raw_b_ff);

      unique case (func_ff)
         FUNC_ADD:  arith_value = t_ff[DATA_W-1:0] +
                                  ((t_ff >= {1'b0, FIELD_P}) ? FOLD_K : '0);
         FUNC_SUB:  arith_value = t_ff[DATA_W-1:0] - (t_ff[DATA_W] ? FOLD_K : '0);
         FUNC_HALF: arith_value = (a_ff >> 1) + (a_ff[0] ? HALF_P1 : '0);
         default:   arith_value = '0;
      endcase

      mul_x = cmd.step_idx[1] ? mx_ff[DATA_W-1:DATA_W/2] : mx_ff[DATA_W/2-1:0];
      mul_y = cmd.step_idx[0] ? my_ff[DATA_W-1:DATA_W/2] : my_ff[DATA_W/2-1:0];

      unique case (pp_idx_ff)
         2'd0:    pp_shifted = {{DATA_W{1'b0}}, pp_ff};
         2'd3:    pp_shifted = {pp_ff, {DATA_W{1'b0}}};
         default: pp_shifted = {{(DATA_W/2){1'b0}}, pp_ff, {(DATA_W/2){1'b0}}};
      endcase

      h_lo = acc_ff[DATA_W+DATA_W/2-1:DATA_W];
      h_hi = acc_ff[2*DATA_W-1:DATA_W+DATA_W/2];

      if (fcarry_ff) begin
         fold_value = fsum_ff;
      end else begin
         fold_value = fsum_ff - ((fsum_ff < FOLD_K) ? TWO_K : FOLD_K);
      end
   end

   always_comb begin
      func_in   = func_ff;
      raw_a_in  = raw_a_ff;
      raw_b_in  = raw_b_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      r_in      = r_ff;
      y_in      = y_ff;
      e_in      = e_ff;
      t_in      = t_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      pp_in     = pp_ff;
      pp_idx_in = pp_idx_ff;
      acc_in    = acc_ff;
      s_in      = s_ff;
      lo_in     = lo_ff;
      fsum_in   = fsum_ff;
      fcarry_in = fcarry_ff;
      res_in    = res_ff;

      if (cmd.capture) begin
         func_in  = func_type'(req_func);
         raw_a_in = req_operand_a;
         raw_b_in = req_operand_b;
      end

      if (cmd.canon) begin
         a_in = canon_a;
         b_in = canon_b;
         y_in = canon_a;
         r_in = FIELD_ONE;
         e_in = (func_ff == FUNC_INV) ? INV_EXP : raw_b_ff;
      end else if (cmd.exp_shift) begin
         e_in = e_ff >> 1;
      end

      if (cmd.arith1) begin
         if (func_ff == FUNC_SUB) begin
            t_in = {1'b0, a_ff} - {1'b0, b_ff};
         end else begin
            t_in = {1'b0, a_ff} + {1'b0, b_ff};
         end
      end

      if (cmd.mul_load) begin
         unique case (cmd.mul_src)
            MS_AB: begin
               mx_in = a_ff;
               my_in = b_ff;
            end
            MS_YY: begin
               mx_in = y_ff;
               my_in = y_ff;
            end
            default: begin
               mx_in = r_ff;
               my_in = y_ff;
            end
         endcase
      end

      if (cmd.mul_step) begin
         pp_in     = {{(DATA_W/2){1'b0}}, mul_x} * {{(DATA_W/2){1'b0}}, mul_y};
         pp_idx_in = cmd.step_idx;
      end

      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + pp_shifted;
      end else if (cmd.sqrt_load) begin
         acc_in = {{DATA_W{1'b0}}, a_ff} << SQRT_SHIFT;
      end

      if (cmd.fold1) begin
         s_in  = {h_lo, {(DATA_W/2){1'b0}}} - {{(DATA_W/2){1'b0}}, h_lo}
               + {{(DATA_W/2){1'b0}}, ~h_hi};
         lo_in = acc_ff[DATA_W-1:0];
      end

      if (cmd.fold2) begin
         {fcarry_in, fsum_in} = {1'b0, s_ff} + {1'b0, lo_ff};
      end

      unique case (cmd.wb_sel)
         WB_R:    r_in = fold_value;
         WB_Y:    y_in = fold_value;
         WB_RES:  res_in = fold_value;
         default: ;
      endcase

      if (cmd.arith2) begin
         res_in = arith_value;
      end else if (cmd.set_one) begin
         res_in = FIELD_ONE;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      raw_a_ff  <= raw_a_in;
      raw_b_ff  <= raw_b_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      r_ff      <= r_in;
      y_ff      <= y_in;
      e_ff      <= e_in;
      t_ff      <= t_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      pp_ff     <= pp_in;
      pp_idx_ff <= pp_idx_in;
      acc_ff    <= acc_in;
      s_ff      <= s_in;
      lo_ff     <= lo_in;
      fsum_ff   <= fsum_in;
      fcarry_ff <= fcarry_in;
      res_ff    <= res_in;
   end

   assign status.func     = func_ff;
   assign status.exp_zero = (e_ff == '0);
   assign status.exp_one  = (e_ff == FIELD_ONE);
   assign status.exp_odd  = e_ff[0];
   assign rsp_result      = res_ff;

endmodule
`default_nettype wire

>>> hdl/gfa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Goldilocks field ALU controller
// Sequences each operation word through the datapath: operand reduction,
// arithmetic, shift-and-fold, multiplier passes and square-and-multiply.
// ----------------------------------------------------------------------------
module gfa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               rsp_ready,
   input  wire gfa_pkg::status_type status,
   output logic                    req_ready,
   output logic                    rsp_valid,
   output gfa_pkg::cmd_type        cmd
);
   import gfa_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff,  kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= KIND_AB;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.canon = 1'b1;
            unique case (status.func)
               FUNC_MUL: begin
                  kind_in  = KIND_AB;
                  state_in = ST_MUL_LOAD;
               end
               FUNC_SQRT: state_in = ST_SQRT;
               FUNC_POW, FUNC_INV: state_in = ST_POW_CHECK;
               default: state_in = ST_ARITH1;
            endcase
         end
         ST_ARITH1: begin
            cmd.arith1 = 1'b1;
            state_in   = ST_ARITH2;
         end
         ST_ARITH2: begin
            cmd.arith2 = 1'b1;
            state_in   = ST_DONE;
         end
         ST_SQRT: begin
            cmd.sqrt_load = 1'b1;
            kind_in       = KIND_SQRT;
            state_in      = ST_FOLD1;
         end
         ST_POW_CHECK: begin
            priority if (status.exp_zero) begin
               cmd.set_one = 1'b1;
               state_in    = ST_DONE;
            end else if (status.exp_one) begin
               kind_in  = KIND_FINAL;
               state_in = ST_MUL_LOAD;
            end else if (status.exp_odd) begin
               kind_in  = KIND_RY;
               state_in = ST_MUL_LOAD;
            end else begin
               kind_in  = KIND_YY;
               state_in = ST_MUL_LOAD;
            end
         end
         ST_MUL_LOAD: begin
            cmd.mul_load = 1'b1;
            unique case (kind_ff)
               KIND_AB: cmd.mul_src = MS_AB;
               KIND_YY: cmd.mul_src = MS_YY;
               default: cmd.mul_src = MS_RY;
            endcase
            state_in = ST_MUL0;
         end
         ST_MUL0: begin
            cmd.mul_step  = 1'b1;
            cmd.step_idx  = 2'd0;
            cmd.acc_clear = 1'b1;
            state_in      = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_step = 1'b1;
            cmd.step_idx = 2'd1;
            cmd.acc_add  = 1'b1;
            state_in     = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_step = 1'b1;
            cmd.step_idx = 2'd2;
            cmd.acc_add  = 1'b1;
            state_in     = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul_step = 1'b1;
            cmd.step_idx = 2'd3;
            cmd.acc_add  = 1'b1;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_FOLD1;
         end
         ST_FOLD1: begin
            cmd.fold1 = 1'b1;
            state_in  = ST_FOLD2;
         end
         ST_FOLD2: begin
            cmd.fold2 = 1'b1;
            state_in  = ST_FOLD3;
         end
         ST_FOLD3: begin
            unique case (kind_ff)
               KIND_RY: begin
                  cmd.wb_sel = WB_R;
                  kind_in    = KIND_YY;
                  state_in   = ST_MUL_LOAD;
               end
               KIND_YY: begin
                  cmd.wb_sel    = WB_Y;
                  cmd.exp_shift = 1'b1;
                  state_in      = ST_POW_CHECK;
               end
               default: begin
                  cmd.wb_sel = WB_RES;
                  state_in   = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // A word is taken only when no result is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_LOAD))
      else $error("accepted word not followed by operand load");

   // After the conditional multiply the same bit always squares the base.
   a_ry_then_yy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD3 && kind_ff == KIND_RY)
      |=> (state_ff == ST_MUL_LOAD && kind_ff == KIND_YY))
      else $error("square step skipped after conditional multiply");

   a_shift_live: assert property (@(posedge clock) disable iff (reset)
      cmd.exp_shift |-> (!status.exp_zero && !status.exp_one))
      else $error("exponent shifted past its last bit");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.canon, cmd.arith1, cmd.arith2, cmd.mul_load, cmd.sqrt_load,
                cmd.fold1, cmd.fold2, cmd.set_one}))
      else $error("conflicting datapath commands");

endmodule
`default_nettype wire

>>> hdl/goldilocks_field_alu_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Goldilocks field ALU
// Add, subtract, multiply, multiply by sqrt(-1), halve, power and inverse
// in the prime field p = 2^64 - 2^32 + 1.
//
//   channel    direction  handshake        payload
//   req_chan   in         valid / ready    func, operand_a, operand_b
//   rsp_chan   out        valid / ready    result
//
// One word is in flight at a time; req_chan.ready is high only when idle.
// Multiply uses one 32x32 multiplier taking four passes plus a three-step
// fold; power and inverse repeat such multiplies by square-and-multiply over
// the exponent bits. Reset is synchronous and returns the controller to
// idle; a stalled result holds until rsp_chan.ready.
// ----------------------------------------------------------------------------
module goldilocks_field_alu_unit (
   input wire logic clock,
   input wire logic reset,
   gfa_req_if.sink  req_chan,
   gfa_rsp_if.source rsp_chan
);
   import gfa_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;
   logic [DATA_W-1:0] rsp_result;

   gfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   gfa_datapath u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .req_func      (req_chan.func),
      .req_operand_a (req_chan.operand_a),
      .req_operand_b (req_chan.operand_b),
      .status        (status),
      .rsp_result    (rsp_result)
   );

   assign req_chan.ready  = req_ready;
   assign rsp_chan.valid  = rsp_valid;
   assign rsp_chan.result = rsp_result;

endmodule
`default_nettype wire
